FILE: src/sbc_pkg.sv
package sbc_pkg;

    // Default slot number width; slots with both top bits set are read-only.
    localparam int SLOT_WIDTH_BITS = 8;

    localparam int PC_W   = 28;
    localparam int DATA_W = 32;
    localparam int SLOT_FIELD_W = 8;

    // APB register map: byte address 4*i, index taken from paddr[2].
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_PROGRAM_LENGTH = 1'b0;

    localparam logic [PC_W-1:0] PROGRAM_LENGTH_RESET = 28'd1;

    typedef struct packed {
        logic [PC_W-1:0]         branch_target;
        logic [SLOT_FIELD_W-1:0] subtrahend_slot;
        logic [SLOT_FIELD_W-1:0] minuend_slot;
        logic [SLOT_FIELD_W-1:0] dest_slot;
    } req_t;

    typedef struct packed {
        logic [PC_W-1:0]          executed_pc;
        logic signed [DATA_W-1:0] difference;
        logic                     slot_written;
        logic                     branch_taken;
        logic [PC_W-1:0]          next_pc;
        logic                     halted;
    } res_t;

endpackage

FILE: src/sbc_ram.sv
module sbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/subtract_branch_core.sv
// An accepted request passes from the read stage into the execute stage, then the output register.
// Throughput: one request per cycle, back to back while the output is not stalled; two
// slot RAM copies serve the A and B reads, the single write per instruction lands in
// both, and forwarding covers a read of the slot written by the instruction just ahead.
// Reset: pc 0, halt clear, program_length 1; data slots read as zero through per-slot
// valid bits, so no clearing pass is needed and requests are taken right after reset.
module subtract_branch_core #(
    parameter int SLOT_WIDTH_BITS = sbc_pkg::SLOT_WIDTH_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         req_valid,
    output logic                         req_ready,
    input  sbc_pkg::req_t                req,
    // result channel
    output logic                         res_valid,
    input  logic                         res_ready,
    output sbc_pkg::res_t                res,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sbc_pkg::PADDR_W-1:0]  paddr,
    input  logic [sbc_pkg::PDATA_W-1:0]  pwdata,
    output logic [sbc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int SW         = SLOT_WIDTH_BITS;
    localparam int SLOT_COUNT = 1 << SW;
    localparam int RAM_DEPTH  = SLOT_COUNT - SLOT_COUNT / 4;
    localparam int IDX_W      = $clog2(RAM_DEPTH);
    localparam int PC_W       = sbc_pkg::PC_W;
    localparam int DATA_W     = sbc_pkg::DATA_W;
    localparam logic [SW-1:0] SLOT_MAX = {SW{1'b1}};

    // Read-only slots: one below the top reads 1, two below reads 2, the rest read 0.
    function automatic logic [1:0] ro_const(input logic [SW-1:0] slot);
        logic [1:0] v;
        v = 2'd0;
        if (slot == SLOT_MAX - 1'b1)
        begin
            v = 2'd1;
        end
        else if (slot == SLOT_MAX - 2'd2)
        begin
            v = 2'd2;
        end
        return v;
    endfunction

    function automatic logic is_ro(input logic [SW-1:0] slot);
        return &slot[SW-1 -: 2];
    endfunction

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [PC_W-1:0] program_length_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == sbc_pkg::REG_PROGRAM_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_length_reg <= sbc_pkg::PROGRAM_LENGTH_RESET;
        end
        else if (cfg_wr)
        begin
            program_length_reg <= pwdata[PC_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == sbc_pkg::REG_PROGRAM_LENGTH)
        begin
            prdata = {{(sbc_pkg::PDATA_W - PC_W){1'b0}}, program_length_reg};
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic res_valid_reg;
    logic s1_go;
    logic accept;

    // Advance the execute stage whenever the output register is free or draining.
    assign s1_go     = s1_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !s1_valid_reg || s1_go;
    assign accept    = req_valid && req_ready;

    // ------------------------------------------------------------------
    // Request decode (read stage): slot numbers keep their low SW bits
    // ------------------------------------------------------------------
    logic [SW-1:0]    a_slot;
    logic [SW-1:0]    b_slot;
    logic [SW-1:0]    d_slot;
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;

    assign a_slot = req.minuend_slot[SW-1:0];
    assign b_slot = req.subtrahend_slot[SW-1:0];
    assign d_slot = req.dest_slot[SW-1:0];
    assign a_idx  = a_slot[IDX_W-1:0];
    assign b_idx  = b_slot[IDX_W-1:0];

    // ------------------------------------------------------------------
    // Slot storage: two RAM copies with a shared write, valid bit per slot
    // ------------------------------------------------------------------
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [DATA_W-1:0]     diff;
    logic [DATA_W-1:0]     ram_a;
    logic [DATA_W-1:0]     ram_b;
    logic [RAM_DEPTH-1:0]  slot_vld_reg;

    sbc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (diff),
        .rd_en   (accept),
        .rd_addr (a_idx),
        .rd_data (ram_a)
    );

    sbc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (diff),
        .rd_en   (accept),
        .rd_addr (b_idx),
        .rd_data (ram_b)
    );

    // Mark a slot as holding real data once it is written; unwritten slots read zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            slot_vld_reg[wr_addr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Execute stage registers
    // ------------------------------------------------------------------
    logic             a_ro_reg;
    logic             b_ro_reg;
    logic             d_wr_reg;
    logic [1:0]       a_const_reg;
    logic [1:0]       b_const_reg;
    logic             d_const_zero_reg;
    logic [IDX_W-1:0] d_idx_reg;
    logic [PC_W-1:0]  target_reg;
    logic             vld_a_reg;
    logic             vld_b_reg;
    logic             fwd_a_reg;
    logic             fwd_b_reg;
    logic [DATA_W-1:0] fwd_data_reg;

    logic             fwd_a_next;
    logic             fwd_b_next;
    logic             vld_a_next;
    logic             vld_b_next;

    // A read that lands on the slot being written this same edge takes the new value.
    assign fwd_a_next = wr_en && (wr_addr == a_idx);
    assign fwd_b_next = wr_en && (wr_addr == b_idx);
    assign vld_a_next = is_ro(a_slot) ? 1'b0 : slot_vld_reg[a_idx];
    assign vld_b_next = is_ro(b_slot) ? 1'b0 : slot_vld_reg[b_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_ro_reg         <= is_ro(a_slot);
            b_ro_reg         <= is_ro(b_slot);
            d_wr_reg         <= !is_ro(d_slot);
            a_const_reg      <= ro_const(a_slot);
            b_const_reg      <= ro_const(b_slot);
            d_const_zero_reg <= (ro_const(d_slot) == 2'd0);
            d_idx_reg        <= d_slot[IDX_W-1:0];
            target_reg       <= req.branch_target;
            vld_a_reg        <= vld_a_next;
            vld_b_reg        <= vld_b_next;
            fwd_a_reg        <= fwd_a_next;
            fwd_b_reg        <= fwd_b_next;
            fwd_data_reg     <= diff;
        end
    end

    // ------------------------------------------------------------------
    // Execute: subtract, write back, branch decision
    // ------------------------------------------------------------------
    logic [PC_W-1:0]   pc_reg;
    logic              halt_reg;
    logic [DATA_W-1:0] val_a;
    logic [DATA_W-1:0] val_b;
    logic              taken;
    logic [PC_W:0]     pc_inc;
    logic [PC_W:0]     next_wide;
    logic              halt_next;

    always_comb
    begin
        if (a_ro_reg)
        begin
            val_a = {{(DATA_W - 2){1'b0}}, a_const_reg};
        end
        else if (fwd_a_reg)
        begin
            val_a = fwd_data_reg;
        end
        else if (vld_a_reg)
        begin
            val_a = ram_a;
        end
        else
        begin
            val_a = '0;
        end

        if (b_ro_reg)
        begin
            val_b = {{(DATA_W - 2){1'b0}}, b_const_reg};
        end
        else if (fwd_b_reg)
        begin
            val_b = fwd_data_reg;
        end
        else if (vld_b_reg)
        begin
            val_b = ram_b;
        end
        else
        begin
            val_b = '0;
        end
    end

    assign diff = val_a - val_b;

    // The destination's stored value is the new difference, or its constant if read-only.
    assign taken     = d_wr_reg ? ((diff == '0) || diff[DATA_W-1]) : d_const_zero_reg;
    assign pc_inc    = {1'b0, pc_reg} + 1'b1;
    assign next_wide = taken ? {1'b0, target_reg} : pc_inc;
    assign halt_next = next_wide >= {1'b0, program_length_reg};

    assign wr_en   = s1_go && !halt_reg && d_wr_reg;
    assign wr_addr = d_idx_reg;

    // Hold pc and halt while halted; later requests only report the held state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            halt_reg <= 1'b0;
        end
        else if (s1_go && !halt_reg)
        begin
            pc_reg   <= next_wide[PC_W-1:0];
            halt_reg <= halt_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    sbc_pkg::res_t res_reg;
    sbc_pkg::res_t res_next;

    always_comb
    begin
        res_next.executed_pc = pc_reg;
        if (halt_reg)
        begin
            res_next.difference   = '0;
            res_next.slot_written = 1'b0;
            res_next.branch_taken = 1'b0;
            res_next.next_pc      = pc_reg;
            res_next.halted       = 1'b1;
        end
        else
        begin
            res_next.difference   = diff;
            res_next.slot_written = d_wr_reg;
            res_next.branch_taken = taken;
            res_next.next_pc      = next_wide[PC_W-1:0];
            res_next.halted       = halt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
